// ----- hw/rtl/conv3x3_zero_padded_stream_defines.svh -----
// assertion macros shared by the conv3x3 stream checker
`ifndef CONV3X3_ZERO_PADDED_STREAM_DEFINES_SVH
`define CONV3X3_ZERO_PADDED_STREAM_DEFINES_SVH

// same-cycle implication, quiet while in reset
`define C3ZP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while in reset
`define C3ZP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// state right after a reset cycle
`define C3ZP_ASSERT_RST(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/c3zp_pkg.sv -----
// shared types and constants of the 3x3 convolution stream
`default_nettype none

package c3zp_pkg;

  localparam int PIX_W        = 8;
  localparam int TAP_W        = 16;
  localparam int NTAPS        = 9;
  localparam int ACC_W        = 28;
  localparam int PROD_W       = PIX_W + 1 + TAP_W;
  localparam int ROW_W        = 12;
  localparam int COL_W        = 8;
  localparam int WROW_W       = 3 * TAP_W;
  localparam int LINE_DEPTH   = 256;
  localparam int MAX_HEIGHT   = 4096;
  localparam int MIN_DIM      = 2;
  localparam int FIFO_DEPTH   = 16;
  localparam int FIFO_AW      = 4;
  localparam int JOBS         = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 48;
  localparam int SHIFT_W      = 4;
  localparam int WIDTH_CFG_W  = 9;
  localparam int HEIGHT_CFG_W = 13;

  localparam logic [WROW_W-1:0]  RST_WT_TOP    = '0;
  localparam logic [WROW_W-1:0]  RST_WT_MID    = 48'h0000_1000_0000;
  localparam logic [WROW_W-1:0]  RST_WT_BOT    = '0;
  localparam logic [COL_W-1:0]   RST_WIDTH_M1  = 8'd7;
  localparam logic [ROW_W-1:0]   RST_HEIGHT_M1 = 12'd7;
  localparam logic [SHIFT_W-1:0] RST_SHIFT     = 4'd12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WT_TOP,
    REG_WT_MID,
    REG_WT_BOT,
    REG_WIDTH,
    REG_HEIGHT,
    REG_SHIFT,
    REG_RELU
  } c3zp_reg_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } c3zp_tag_t;

  // one output pixel on its way through the multiply-accumulate chain
  typedef struct packed {
    logic                        valid;
    logic [NTAPS-1:0][PIX_W-1:0] pix;
    c3zp_tag_t                   tag;
    logic signed [ACC_W-1:0]     psum;
  } c3zp_job_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] value;
    c3zp_tag_t               tag;
  } c3zp_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/c3zp_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none

module c3zp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/c3zp_cell.sv -----
// one multiply-accumulate cell of the convolution chain
`default_nettype none

module c3zp_cell import c3zp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic signed [TAP_W-1:0] tap,
  input  c3zp_job_t               job_in,
  output c3zp_job_t               job_out
);

  logic signed [PROD_W-1:0]    prod;
  logic                        valid;
  logic [NTAPS-1:0][PIX_W-1:0] pix;
  c3zp_tag_t                   tag;
  logic signed [ACC_W-1:0]     psum;

  // this cell always works on the lowest pixel slot
  assign prod = $signed({1'b0, job_in.pix[0]}) * tap;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= job_in.valid;
    end
    pix  <= job_in.pix >> PIX_W;
    tag  <= job_in.tag;
    psum <= job_in.psum + ACC_W'(prod);
  end

  always_comb begin
    job_out.valid = valid;
    job_out.pix   = pix;
    job_out.tag   = tag;
    job_out.psum  = psum;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/c3zp_fifo.sv -----
// result queue between the accumulate chain and the output port
`default_nettype none

module c3zp_fifo import c3zp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  c3zp_result_t push_data,
  input  logic         pop,
  output c3zp_result_t pop_data,
  output logic         not_empty
);

  c3zp_result_t       mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      priority if (push && !pop) begin
        count <= count + (FIFO_AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (FIFO_AW+1)'(1);
      end else begin
        count <= count;
      end
    end
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/conv3x3_zero_padded_stream.sv -----
// 3x3 zero-padded convolution over a raster pixel stream
//
// pixels enter on in_valid/in_stall/pixel in raster order, one beat per
// pixel. each beat yields zero to four results on out_valid/out_stall with
// filtered_value, out_row, out_col and last_of_run (set on the final result
// that a pixel releases). registers are written on cfg_valid/cfg_ready,
// always ready, by the user only while the block is idle; the block does
// not enforce this. writing width or height restarts the frame at row 0,
// column 0. a pixel holds the front end until its results are issued into
// the nine-cell multiply-accumulate chain, one per cycle while queue credit
// lasts; pixels releasing at most one result stream likewise, one per cycle.
// the first result of a pixel passes the line read, the window update, the
// nine chain cells and the result queue before it is shown.
// a 16-entry result queue with credit tracking keeps the chain running while
// the receiver stalls; input stalls while earlier results wait to issue.
// reset clears counters, window and queue; line buffers are not cleared.
`default_nettype none

module conv3x3_zero_padded_stream import c3zp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [PIX_W-1:0]        pixel,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [ACC_W-1:0] filtered_value,
  output logic [ROW_W-1:0]        out_row,
  output logic [COL_W-1:0]        out_col,
  output logic                    last_of_run,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  // configuration
  logic [2:0][WROW_W-1:0] wt_rows;
  logic [COL_W-1:0]       w_m1;
  logic [ROW_W-1:0]       h_m1;
  logic [SHIFT_W-1:0]     res_shift;
  logic                   relu_on;
  logic                   cfg_we;
  logic                   geom_we;
  c3zp_reg_t              cfg_sel;
  logic [WIDTH_CFG_W-1:0]  wv;
  logic [HEIGHT_CFG_W-1:0] hv;
  logic [COL_W-1:0]       w_m1_next;
  logic [ROW_W-1:0]       h_m1_next;

  // frame position and first stage
  logic [ROW_W-1:0] row_cnt;
  logic [COL_W-1:0] col_cnt;
  logic             in_acc;
  logic             s1_valid;
  logic [PIX_W-1:0] s1_pixel;
  logic [ROW_W-1:0] s1_row;
  logic [COL_W-1:0] s1_col;
  logic             s1_adv;
  logic [2*PIX_W-1:0] line_rd;

  // window and burst of pending results
  logic [2:0][2:0][PIX_W-1:0] win;
  logic [2:0][2:0][PIX_W-1:0] win_next;
  logic [2:0][2:0][PIX_W-1:0] b_win;
  logic [JOBS-1:0]            jobs_new;
  logic [2:0]                 row_ex_new;
  logic [2:0]                 col_ex_new;
  logic [JOBS-1:0]            b_jobs;
  logic [2:0]                 b_row_ex;
  logic [2:0]                 b_col_ex;
  logic [ROW_W-1:0]           b_row;
  logic [COL_W-1:0]           b_col;
  logic [1:0]                 sel;
  logic [JOBS-1:0]            sel_hot;
  logic [JOBS-1:0]            rem;
  logic                       issue;
  logic                       burst_free;
  logic [3:0][3:0][PIX_W-1:0] ext;
  logic [NTAPS-1:0][PIX_W-1:0] issue_pix;

  // chain and output
  c3zp_job_t        chain [NTAPS+1];
  logic [FIFO_AW:0] credit;
  logic             credit_ok;
  logic             out_acc;
  logic signed [ACC_W-1:0] shifted;
  c3zp_result_t     res_in;
  c3zp_result_t     res_out;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign cfg_sel   = c3zp_reg_t'(cfg_index);
  assign geom_we   = cfg_we && (cfg_sel == REG_WIDTH || cfg_sel == REG_HEIGHT);
  assign wv        = cfg_data[WIDTH_CFG_W-1:0];
  assign hv        = cfg_data[HEIGHT_CFG_W-1:0];

  // out-of-range geometry is clamped once, at write time
  always_comb begin
    priority if (wv < WIDTH_CFG_W'(MIN_DIM)) begin
      w_m1_next = COL_W'(MIN_DIM - 1);
    end else if (wv > WIDTH_CFG_W'(LINE_DEPTH)) begin
      w_m1_next = COL_W'(LINE_DEPTH - 1);
    end else begin
      w_m1_next = COL_W'(wv - WIDTH_CFG_W'(1));
    end
    priority if (hv < HEIGHT_CFG_W'(MIN_DIM)) begin
      h_m1_next = ROW_W'(MIN_DIM - 1);
    end else if (hv > HEIGHT_CFG_W'(MAX_HEIGHT)) begin
      h_m1_next = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      h_m1_next = ROW_W'(hv - HEIGHT_CFG_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wt_rows[0] <= RST_WT_TOP;
      wt_rows[1] <= RST_WT_MID;
      wt_rows[2] <= RST_WT_BOT;
      w_m1       <= RST_WIDTH_M1;
      h_m1       <= RST_HEIGHT_M1;
      res_shift  <= RST_SHIFT;
      relu_on    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        REG_WT_TOP: wt_rows[0] <= cfg_data[WROW_W-1:0];
        REG_WT_MID: wt_rows[1] <= cfg_data[WROW_W-1:0];
        REG_WT_BOT: wt_rows[2] <= cfg_data[WROW_W-1:0];
        REG_WIDTH:  w_m1       <= w_m1_next;
        REG_HEIGHT: h_m1       <= h_m1_next;
        REG_SHIFT:  res_shift  <= cfg_data[SHIFT_W-1:0];
        REG_RELU:   relu_on    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // ------------------------------------------------------ input and counters
  assign in_stall = s1_valid && !burst_free;
  assign in_acc   = in_valid && !in_stall;
  assign s1_adv   = s1_valid && burst_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else begin
      priority if (geom_we) begin
        row_cnt <= '0;
        col_cnt <= '0;
      end else if (in_acc) begin
        if (col_cnt == w_m1) begin
          col_cnt <= '0;
          row_cnt <= (row_cnt == h_m1) ? '0 : row_cnt + ROW_W'(1);
        end else begin
          col_cnt <= col_cnt + COL_W'(1);
        end
      end else begin
        row_cnt <= row_cnt;
        col_cnt <= col_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (in_acc) begin
      s1_pixel <= pixel;
      s1_row   <= row_cnt;
      s1_col   <= col_cnt;
    end
  end

  // both line buffers share one address: {older, newer}
  c3zp_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (LINE_DEPTH)
  ) u_lines (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data ({line_rd[PIX_W-1:0], s1_pixel}),
    .rd_en   (in_acc),
    .rd_addr (col_cnt),
    .rd_data (line_rd)
  );

  // ------------------------------------------------------------- window
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_next[k][0] = win[k][1];
      win_next[k][1] = win[k][2];
    end
    win_next[0][2] = line_rd[2*PIX_W-1:PIX_W];
    win_next[1][2] = line_rd[PIX_W-1:0];
    win_next[2][2] = s1_pixel;
  end

  // results released by this pixel, upper-left first
  always_comb begin
    jobs_new[0] = (s1_row != '0) && (s1_col != '0);
    jobs_new[1] = (s1_row != '0) && (s1_col == w_m1);
    jobs_new[2] = (s1_row == h_m1) && (s1_col != '0);
    jobs_new[3] = (s1_row == h_m1) && (s1_col == w_m1);
    // window rows and columns that lie inside the frame
    row_ex_new  = {1'b1, s1_row != '0, s1_row > ROW_W'(1)};
    col_ex_new  = {1'b1, s1_col != '0, s1_col > COL_W'(1)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win    <= '0;
      b_jobs <= '0;
    end else if (s1_adv) begin
      win    <= win_next;
      b_jobs <= jobs_new;
    end else if (issue) begin
      b_jobs <= rem;
    end
    if (s1_adv) begin
      b_win    <= win_next;
      b_row_ex <= row_ex_new;
      b_col_ex <= col_ex_new;
      b_row    <= s1_row;
      b_col    <= s1_col;
    end
  end

  // ------------------------------------------------------------- issue
  always_comb begin
    priority if (b_jobs[0]) begin
      sel = 2'd0;
    end else if (b_jobs[1]) begin
      sel = 2'd1;
    end else if (b_jobs[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
  end

  assign sel_hot    = JOBS'(1) << sel;
  assign rem        = b_jobs & ~sel_hot;
  assign credit_ok  = credit < (FIFO_AW+1)'(FIFO_DEPTH);
  assign issue      = (b_jobs != '0) && credit_ok;
  assign burst_free = (b_jobs == '0) || (issue && rem == '0);

  // masked window padded with a zero row and column for the shifted outputs
  for (genvar gr = 0; gr < 4; gr++) begin : g_ext_r
    for (genvar gc = 0; gc < 4; gc++) begin : g_ext_c
      if (gr < 3 && gc < 3) begin : g_in
        assign ext[gr][gc] = (b_row_ex[gr] && b_col_ex[gc]) ? b_win[gr][gc] : '0;
      end else begin : g_pad
        assign ext[gr][gc] = '0;
      end
    end
  end

  for (genvar kr = 0; kr < 3; kr++) begin : g_pix_r
    for (genvar kc = 0; kc < 3; kc++) begin : g_pix_c
      assign issue_pix[kr*3+kc] =
        ext[2'(kr) + {1'b0, sel[1]}][2'(kc) + {1'b0, sel[0]}];
    end
  end

  always_comb begin
    chain[0].valid    = issue;
    chain[0].pix      = issue_pix;
    chain[0].tag.row  = sel[1] ? b_row : b_row - ROW_W'(1);
    chain[0].tag.col  = sel[0] ? b_col : b_col - COL_W'(1);
    chain[0].tag.last = (rem == '0);
    chain[0].psum     = '0;
  end

  // ------------------------------------------------------------- chain
  for (genvar k = 0; k < NTAPS; k++) begin : g_cell
    localparam int KR = k / 3;
    localparam int KC = k % 3;
    c3zp_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tap     ($signed(wt_rows[KR][KC*TAP_W +: TAP_W])),
      .job_in  (chain[k]),
      .job_out (chain[k+1])
    );
  end

  // ------------------------------------------------------------- output
  assign shifted = chain[NTAPS].psum >>> res_shift;

  always_comb begin
    res_in.tag   = chain[NTAPS].tag;
    res_in.value = (relu_on && shifted < 0) ? '0 : shifted;
  end

  assign out_acc = out_valid && !out_stall;

  // results issued and not yet taken never exceed the queue depth
  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      priority if (issue && !out_acc) begin
        credit <= credit + (FIFO_AW+1)'(1);
      end else if (out_acc && !issue) begin
        credit <= credit - (FIFO_AW+1)'(1);
      end else begin
        credit <= credit;
      end
    end
  end

  c3zp_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (chain[NTAPS].valid),
    .push_data (res_in),
    .pop       (out_acc),
    .pop_data  (res_out),
    .not_empty (out_valid)
  );

  assign filtered_value = res_out.value;
  assign out_row        = res_out.tag.row;
  assign out_col        = res_out.tag.col;
  assign last_of_run    = res_out.tag.last;

endmodule

`default_nettype wire

// ----- hw/rtl/c3zp_checker.sv -----
// port-level checks for the conv3x3 stream, bound to the top level
`default_nettype none

`include "conv3x3_zero_padded_stream_defines.svh"

module c3zp_checker import c3zp_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [ACC_W-1:0] filtered_value,
  input logic [ROW_W-1:0]        out_row,
  input logic [COL_W-1:0]        out_col,
  input logic                    last_of_run,
  input logic                    cfg_valid,
  input logic                    cfg_ready,
  input logic [CFG_IDX_W-1:0]    cfg_index,
  input logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam logic signed [ACC_W-1:0] VALUE_MIN = -28'sd75202560;
  localparam logic signed [ACC_W-1:0] VALUE_MAX = 28'sd75200265;

  logic relu_on;
  logic out_held;
  logic in_range;
  logic [ACC_W+ROW_W+COL_W:0] out_beat;

  assign out_held = out_valid && out_stall;
  assign out_beat = {filtered_value, out_row, out_col, last_of_run};
  assign in_range = (filtered_value >= VALUE_MIN) && (filtered_value <= VALUE_MAX);

  // shadow of the clamp enable as written on the config port
  always_ff @(posedge clk) begin
    if (rst) begin
      relu_on <= 1'b0;
    end else if (cfg_valid && cfg_ready && cfg_index == REG_RELU) begin
      relu_on <= cfg_data[0];
    end
  end

  `C3ZP_ASSERT_NXT(a_out_hold, out_held, out_valid && $stable(out_beat), "stalled beat changed")
  `C3ZP_ASSERT_RST(a_reset_quiet, !out_valid && !in_stall, "block not quiet after reset")
  `C3ZP_ASSERT_IMP(a_relu_clamp, out_valid && relu_on, !filtered_value[ACC_W-1], "negative result")
  `C3ZP_ASSERT_IMP(a_value_range, out_valid, in_range, "result outside reachable range")

endmodule

bind conv3x3_zero_padded_stream c3zp_checker u_checker (.*);

`default_nettype wire
